FILE: rtl/core/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest block.
package sha1md_pkg;

    localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

    localparam logic [31:0] IV_WORD [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARKER   = 8'h80;
    localparam logic [3:0] LEN_HI_WORD  = 4'd14;
    localparam logic [3:0] LEN_LO_WORD  = 4'd15;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [3:0] LAST_LOAD    = 4'd15;
    localparam logic [2:0] LAST_DIGEST  = 3'd4;

    typedef struct packed {
        logic [31:0] data;
        logic        last;
    } word_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        FRONT_COLLECT,
        FRONT_PAD
    } front_state_t;

    typedef enum logic [1:0] {
        CORE_LOAD,
        CORE_ROUND,
        CORE_FOLD,
        CORE_EMIT
    } core_state_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = K_ROUND_0;
        else if (t < 7'd40)
            k = K_ROUND_1;
        else if (t < 7'd60)
            k = K_ROUND_2;
        else
            k = K_ROUND_3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

FILE: rtl/core/sha1_message_digest.sv
// Top level of the SHA-1 digest block: byte intake, word queue, compression core.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------------
//  in      | into core | in_valid/in_stall | msg_byte, has_byte, end_of_message
//  out     | from core | out_valid/out_stall | digest_word, last_word
//
// One byte is taken per cycle while the word queue has room; a padding run after
// the end item stalls input while its 3 to 18 words are queued, longer
// while the queue is full.
// Each 64-byte block is loaded into the core as 16 words, then runs 80 rounds and
// one fold step; meanwhile bytes keep entering the queue while it has room.
// Reset is asynchronous; the chaining value returns to its initial value at reset
// and after each digest. Output stalls hold the core in its emit state only.
module sha1_message_digest
    import sha1md_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic        last_word
);

    logic          q_push;
    logic          q_pop;
    word_entry_t   q_entry;
    word_entry_t   q_head;
    queue_status_t q_status;

    sha1md_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .msg_byte       (msg_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .q_full         (q_status.full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    sha1md_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    sha1md_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .last_word   (last_word)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("word queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_status.empty))
        else $error("word queue read while empty");

    a_pad_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_message) |=> in_stall)
        else $error("input not stalled during padding");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> !(out_valid && last_word))
        else $error("two final digest words in a row");

endmodule

FILE: rtl/core/sha1md_front.sv
// Byte intake: packs bytes into big-endian words, counts length, generates padding.
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        q_full,
    output logic        q_push,
    output word_entry_t q_entry
);

    front_state_t state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  total_reg, total_next;
    logic [31:0]  acc_reg, acc_next;
    logic         first_reg, first_next;
    logic         long_reg, long_next;

    logic         accept;
    logic [3:0]   pad_idx;
    logic [1:0]   lane;
    logic [31:0]  marker_word;

    assign pad_idx = fill_reg[5:2];
    assign lane    = fill_reg[1:0];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (l < int'(lane))
                marker_word[31 - 8 * l -: 8] = acc_reg[31 - 8 * l -: 8];
            else if (l == int'(lane))
                marker_word[31 - 8 * l -: 8] = PAD_MARKER;
            else
                marker_word[31 - 8 * l -: 8] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_COLLECT;
            fill_reg  <= '0;
            total_reg <= '0;
            first_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            first_reg <= first_next;
            long_reg  <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        long_next  = long_reg;
        in_stall   = q_full || (state_reg == FRONT_PAD);
        accept     = in_valid && !in_stall;
        q_push     = 1'b0;
        q_entry    = '{data: '0, last: 1'b0};

        unique case (state_reg)
            FRONT_COLLECT:
            begin
                if (accept)
                begin
                    if (has_byte)
                    begin
                        acc_next[31 - 8 * lane -: 8] = msg_byte;
                        fill_next  = fill_reg + 6'd1;
                        total_next = total_reg + 61'd1;
                        if (lane == 2'd3)
                        begin
                            q_push  = 1'b1;
                            q_entry = '{data: {acc_reg[31:8], msg_byte}, last: 1'b0};
                        end
                    end
                    if (end_of_message)
                    begin
                        state_next = FRONT_PAD;
                        first_next = 1'b1;
                    end
                end
            end
            FRONT_PAD:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    first_next = 1'b0;
                    fill_next  = {pad_idx + 4'd1, 2'b00};
                    if (first_reg)
                    begin
                        q_entry   = '{data: marker_word, last: 1'b0};
                        long_next = (pad_idx == LEN_HI_WORD);
                    end
                    else if (pad_idx == LEN_HI_WORD && !long_reg)
                    begin
                        q_entry = '{data: total_reg[60:29], last: 1'b0};
                    end
                    else if (pad_idx == LEN_LO_WORD && !long_reg)
                    begin
                        q_entry    = '{data: {total_reg[28:0], 3'b000}, last: 1'b1};
                        state_next = FRONT_COLLECT;
                        fill_next  = '0;
                        total_next = '0;
                    end
                    else
                    begin
                        if (pad_idx == LEN_LO_WORD)
                            long_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = FRONT_COLLECT;
            end
        endcase
    end

endmodule

FILE: rtl/core/sha1md_queue.sv
// Word queue between byte intake and compression core.
module sha1md_queue
    import sha1md_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  word_entry_t   push_entry,
    input  logic          pop,
    output word_entry_t   head,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    word_entry_t      store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head         = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: rtl/core/sha1md_core.sv
// Compression core: schedule window, 80 rounds, chaining value, digest output register.
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  word_entry_t   q_head,
    input  queue_status_t q_status,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   digest_word,
    output logic          last_word
);

    core_state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        final_reg, final_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] h_reg [5];
    logic [31:0] h_next [5];
    logic        out_valid_reg, out_valid_next;
    logic [31:0] digest_reg, digest_next;
    logic        last_reg, last_next;

    logic        out_load;
    logic [31:0] sched_mix;
    logic [31:0] round_sum;

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign last_word   = last_reg;

    assign sched_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign round_sum = {a_reg[26:0], a_reg[31:27]} + round_f(cnt_reg, b_reg, c_reg, d_reg)
                     + e_reg + round_k(cnt_reg) + w_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_LOAD;
            cnt_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
                h_reg[i] <= IV_WORD[i];
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 5; i++)
                h_reg[i] <= h_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
            w_reg[i] <= w_next[i];
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        digest_reg <= digest_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        final_next  = final_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        digest_next = digest_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        out_load    = (state_reg == CORE_EMIT) && (!out_valid_reg || !out_stall);
        out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

        unique case (state_reg)
            CORE_LOAD:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    for (int i = 0; i < 15; i++)
                        w_next[i] = w_reg[i + 1];
                    w_next[15] = q_head.data;
                    if (cnt_reg[3:0] == LAST_LOAD)
                    begin
                        state_next = CORE_ROUND;
                        cnt_next   = '0;
                        final_next = q_head.last;
                        a_next     = h_reg[0];
                        b_next     = h_reg[1];
                        c_next     = h_reg[2];
                        d_next     = h_reg[3];
                        e_next     = h_reg[4];
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            CORE_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_next[i] = w_reg[i + 1];
                w_next[15] = {sched_mix[30:0], sched_mix[31]};
                a_next = round_sum;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = CORE_FOLD;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            CORE_FOLD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                state_next = final_reg ? CORE_EMIT : CORE_LOAD;
            end
            CORE_EMIT:
            begin
                if (out_load)
                begin
                    digest_next = h_reg[cnt_reg[2:0]];
                    last_next   = (cnt_reg[2:0] == LAST_DIGEST);
                    if (cnt_reg[2:0] == LAST_DIGEST)
                    begin
                        state_next = CORE_LOAD;
                        cnt_next   = '0;
                        final_next = 1'b0;
                        for (int i = 0; i < 5; i++)
                            h_next[i] = IV_WORD[i];
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            default:
            begin
                state_next = CORE_LOAD;
            end
        endcase
    end

endmodule

FILE: bench/tb_sha1_message_digest.sv
// Self-checking testbench for sha1_message_digest: directed table, then random messages.
module tb_sha1_message_digest;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;
    localparam logic [159:0] NO_DIGEST    = '0;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [7:0]   msg;
        logic         hb;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic        last_word;

    sha1_message_digest dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .msg_byte       (msg_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .last_word      (last_word)
    );

    // predictor state
    logic [31:0] chain_h [5];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] byte_total;

    logic [32:0] pending_digest_words [$];
    stim_row_t   table_rows [$];
    int          errors;
    int          idle_cycles;
    int          items_sent;
    int          digests_sent;
    int          burst_left;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        fill = 0;
        byte_total = '0;
    endfunction

    function automatic void mix_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, nx;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 80; t++)
            w[t] = rol32(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            nx = rol32(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = nx;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // returns 1 when the item closes a message; digest then holds h0..h4
    function automatic logic hash_absorb(input logic [7:0] msg, input logic hb,
                                         input logic eom, output logic [159:0] digest);
        logic [63:0] bit_len;
        digest = '0;
        if (hb)
        begin
            blk[fill] = msg;
            fill = (fill + 1) & 63;
            byte_total = byte_total + 61'd1;
            if (fill == 0)
                mix_block();
        end
        if (!eom)
            return 1'b0;
        blk[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++)
            blk[i] = 8'h00;
        if (fill >= 56)
        begin
            mix_block();
            for (int i = 0; i < 64; i++)
                blk[i] = 8'h00;
        end
        bit_len = {byte_total, 3'b000};
        for (int j = 0; j < 8; j++)
            blk[56 + j] = bit_len[63 - 8*j -: 8];
        mix_block();
        digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
        restart_hash();
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] msg, input logic hb, input logic eom,
                                    input logic known, input logic [159:0] digest);
        stim_row_t r;
        r.msg = msg;
        r.hb = hb;
        r.eom = eom;
        r.known = known;
        r.digest = digest;
        table_rows.push_back(r);
    endfunction

    // sender bursts: random gap before each new burst
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_item(input logic [7:0] msg, input logic hb, input logic eom,
                             input logic known, input logic [159:0] typed);
        logic [159:0] digest;
        logic         done;
        pace();
        @(negedge clk);
        in_valid       <= 1'b1;
        msg_byte       <= msg;
        has_byte       <= hb;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        done = hash_absorb(msg, hb, eom, digest);
        if (done)
        begin
            if (known)
                digest = typed;
            for (int i = 0; i < 5; i++)
                pending_digest_words.push_back({i == 4, digest[159 - 32*i -: 32]});
            digests_sent++;
        end
        if (hb || eom)
            items_sent++;
    endtask

    task automatic send_noise();
        send_item(8'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
    endtask

    task automatic send_message(input int len);
        logic end_only;
        end_only = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send_item(8'($urandom), 1'b1, (i == len - 1) && !end_only, 1'b0, NO_DIGEST);
        end
        if (end_only)
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digest_words.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, switching at random among four modes
    initial
    begin
        int mode;
        int phase_left;
        int cyc;
        out_stall = 1'b0;
        mode = 0;
        phase_left = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            cyc++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (cyc % 4 != 0);
            endcase
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        logic [32:0] exp_word;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && !out_stall)
            begin
                if (pending_digest_words.size() == 0)
                begin
                    $display("%0t: unexpected transfer: digest_word %h last_word %b",
                             $realtime, digest_word, last_word);
                    errors++;
                end
                else
                begin
                    exp_word = pending_digest_words.pop_front();
                    if (digest_word !== exp_word[31:0])
                    begin
                        $display("%0t: digest_word mismatch: expected %h, actual %h",
                                 $realtime, exp_word[31:0], digest_word);
                        errors++;
                    end
                    if (last_word !== exp_word[32])
                    begin
                        $display("%0t: last_word mismatch: expected %b, actual %b",
                                 $realtime, exp_word[32], last_word);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        msg_byte       = 8'h00;
        has_byte       = 1'b0;
        end_of_message = 1'b0;
        errors         = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        digests_sent   = 0;
        burst_left     = 0;
        restart_hash();

        add_row(8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h55, 1'b0, 1'b1, 1'b1, DIGEST_ABC);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST);
        add_row(8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h7F, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'h01, 1'b1, 1'b0, 1'b0, NO_DIGEST);
        add_row(8'hAA, 1'b0, 1'b1, 1'b0, NO_DIGEST);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            send_item(table_rows[i].msg, table_rows[i].hb, table_rows[i].eom,
                      table_rows[i].known, table_rows[i].digest);
        hold_until_drained();

        // marker lands in the length word, so padding takes two blocks
        send_message(58);

        while (items_sent < 100 || digests_sent < 12)
        begin
            len = $urandom_range(0, 12);
            send_message(len);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digest_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_digest_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
